@@ rtl/ssbf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssbf_pkg
// shared types and constants of the store sequence bloom filter
// ----------------------------------------------------------------------------
package ssbf_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int WAYS          = 4;
  localparam int SETS          = TABLE_ENTRIES / WAYS;
  localparam int SET_BITS      = $clog2(SETS);
  localparam int WAY_BITS      = $clog2(WAYS);
  localparam int TAG_BITS      = 16;
  localparam int ADDR_SHIFT    = 3;
  localparam int OFFSET_BITS   = 3;
  localparam int SEQ_BITS      = 32;
  localparam int SIZE_BITS     = 4;
  localparam int ADDR_BITS     = 48;
  localparam int UIDX_BITS     = $clog2(TABLE_ENTRIES);

  typedef enum logic [2:0] {
    OP_COMMIT   = 3'd0,
    OP_CHECK    = 3'd1,
    OP_RESERVE  = 3'd2,
    OP_COMPLETE = 3'd3,
    OP_LOOKUP   = 3'd4
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [TAG_BITS-1:0]    tag;
    logic [SEQ_BITS-1:0]    seq;
    logic [OFFSET_BITS-1:0] offset;
    logic [SIZE_BITS-1:0]   size;
  } way_t;

  typedef way_t [WAYS-1:0] row_t;

  typedef struct packed {
    logic                en;
    logic [SET_BITS-1:0] set;
    logic [WAYS-1:0]     valid;
    row_t                row;
  } tag_wr_t;

endpackage

@@ rtl/store_sequence_bloom_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// store_sequence_bloom_filter
// tracks youngest store sequence numbers and screens loads for verification
// ----------------------------------------------------------------------------
// The edge that accepts an item reads one tagged-table row (all ways of the
// set) and one untagged entry into registers, and in the EXEC state the block
// compares the ways, decides, writes the row back and loads the result
// register. in_stall is high while the block is in EXEC, which stretches for
// as long as the result register is full and stalled. The tables are empty
// right after reset.
module store_sequence_bloom_filter
  import ssbf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0]             op,
  input  logic [ADDR_BITS-1:0]   addr,
  input  logic [SIZE_BITS-1:0]   access_size,
  input  logic [SEQ_BITS-1:0]    seq,
  input  logic [SEQ_BITS-1:0]    bound_seq,
  input  logic                   bypass_hint,
  input  logic                   split_access,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   verify_skip,
  output logic                   hit,
  output logic [SEQ_BITS-1:0]    last_seq
);

  state_t state, state_next;

  logic [2:0]           r_op;
  logic [ADDR_BITS-1:0] r_addr;
  logic [SIZE_BITS-1:0] r_size;
  logic [SEQ_BITS-1:0]  r_seq;
  logic [SEQ_BITS-1:0]  r_bound;
  logic                 r_pbyp;
  logic                 r_split;

  logic                 accept;
  logic                 done;
  row_t                 row;
  logic [WAYS-1:0]      row_valid;
  logic [SEQ_BITS-1:0]  useq;
  tag_wr_t              twr;
  logic                 uwr_en;

  logic [SET_BITS-1:0]  in_set;
  logic [UIDX_BITS-1:0] in_uidx;
  logic [SET_BITS-1:0]  r_set;
  logic [TAG_BITS-1:0]  r_tag;
  logic [UIDX_BITS-1:0] r_uidx;

  logic [WAYS-1:0]      hit_vec;
  logic                 any_hit;
  logic [WAY_BITS-1:0]  hit_way;
  logic [WAY_BITS-1:0]  alloc_way;
  logic                 found_free;
  logic [SEQ_BITS-1:0]  young;
  way_t                 hw;
  logic                 res_skip;
  logic [SEQ_BITS-1:0]  res_last;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign done     = (state == ST_EXEC) && (!out_valid || !out_stall);

  assign in_set  = addr[ADDR_SHIFT +: SET_BITS];
  assign in_uidx = addr[UIDX_BITS-1:0] ^ addr[UIDX_BITS +: UIDX_BITS]
                 ^ addr[2*UIDX_BITS +: UIDX_BITS];
  assign r_set   = r_addr[ADDR_SHIFT +: SET_BITS];
  assign r_tag   = r_addr[ADDR_SHIFT + SET_BITS +: TAG_BITS];
  assign r_uidx  = r_addr[UIDX_BITS-1:0] ^ r_addr[UIDX_BITS +: UIDX_BITS]
                 ^ r_addr[2*UIDX_BITS +: UIDX_BITS];

  always_ff @(posedge clk) begin
    if (accept) begin
      r_op    <= op;
      r_addr  <= addr;
      r_size  <= access_size;
      r_seq   <= seq;
      r_bound <= bound_seq;
      r_pbyp  <= bypass_hint;
      r_split <= split_access;
    end
  end

  ssbf_tag_mem u_tag (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_set   (in_set),
    .rd_row   (row),
    .rd_valid (row_valid),
    .wr       (twr)
  );

  ssbf_utab u_utab (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_idx  (in_uidx),
    .rd_data (useq),
    .wr_en   (uwr_en),
    .wr_idx  (r_uidx),
    .wr_data (r_seq)
  );

  // way compare, replacement choice and youngest valid sequence
  always_comb begin
    any_hit    = 1'b0;
    hit_way    = '0;
    found_free = 1'b0;
    alloc_way  = '0;
    young      = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = row_valid[w] && (row[w].tag == r_tag);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        any_hit = 1'b1;
        hit_way = WAY_BITS'(w);
      end
      if (!row_valid[w]) begin
        found_free = 1'b1;
        alloc_way  = WAY_BITS'(w);
      end
    end
    if (!found_free) begin
      for (int w = 1; w < WAYS; w++) begin
        if (row[w].seq < row[alloc_way].seq) begin
          alloc_way = WAY_BITS'(w);
        end
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if (row_valid[w] && (row[w].seq > young)) begin
        young = row[w].seq;
      end
    end
  end

  assign hw = row[hit_way];

  always_comb begin
    state_next = state;
    twr.en     = 1'b0;
    twr.set    = r_set;
    twr.valid  = row_valid;
    twr.row    = row;
    uwr_en     = 1'b0;
    res_skip   = 1'b0;
    res_last   = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (r_op)
          OP_COMMIT: begin
            twr.en = done;
            uwr_en = done;
            if (any_hit) begin
              twr.row[hit_way] = '{r_tag, r_seq, r_addr[OFFSET_BITS-1:0], r_size};
            end else begin
              twr.row[alloc_way]   = '{r_tag, r_seq, r_addr[OFFSET_BITS-1:0], r_size};
              twr.valid[alloc_way] = 1'b1;
            end
          end
          OP_CHECK: begin
            if (r_split) begin
              res_skip = 1'b0;
            end else if (r_pbyp) begin
              res_skip = any_hit && (hw.seq == r_bound)
                      && (hw.offset == r_addr[OFFSET_BITS-1:0]) && (hw.size == r_size);
            end else if (any_hit) begin
              res_skip = (hw.seq != '0) && (hw.seq <= r_bound);
            end else begin
              res_skip = ((young != '0) && (young <= r_bound)) || (useq <= r_bound);
            end
          end
          OP_RESERVE: begin
            if (!any_hit) begin
              twr.en               = done;
              twr.row[alloc_way]   = '{r_tag, r_seq, '0, '0};
              twr.valid[alloc_way] = 1'b1;
            end
          end
          OP_COMPLETE: begin
            if (any_hit && (hw.seq < r_seq)) begin
              twr.en               = done;
              twr.row[hit_way].seq = r_seq;
            end
          end
          OP_LOOKUP: begin
            res_last = any_hit ? hw.seq : '0;
          end
          default: begin
          end
        endcase
        if (done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      verify_skip <= res_skip;
      hit         <= any_hit && (r_op <= OP_LOOKUP);
      last_seq    <= res_last;
    end
  end

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("input taken while an item is in flight");

  a_result_after_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_EXEC))
    else $error("result without an executed item");

  a_lookup_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> last_seq == '0)
    else $error("last_seq nonzero on a miss");
`endif

endmodule

@@ rtl/ssbf_tag_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssbf_tag_mem
// set-associative tagged table, one row per set, valid bits in flops
// ----------------------------------------------------------------------------
module ssbf_tag_mem
  import ssbf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [SET_BITS-1:0] rd_set,
  output row_t                rd_row,
  output logic [WAYS-1:0]     rd_valid,
  input  tag_wr_t             wr
);

  row_t            mem [SETS];
  logic [WAYS-1:0] valid [SETS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.set] <= wr.row;
    end
    if (rd_en) begin
      rd_row <= mem[rd_set];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SETS; i++) begin
        valid[i] <= '0;
      end
      rd_valid <= '0;
    end else begin
      if (wr.en) begin
        valid[wr.set] <= wr.valid;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_set];
      end
    end
  end

endmodule

@@ rtl/ssbf_utab.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssbf_utab
// untagged sequence table, unwritten entries read as zero
// ----------------------------------------------------------------------------
module ssbf_utab
  import ssbf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  logic [UIDX_BITS-1:0] rd_idx,
  output logic [SEQ_BITS-1:0]  rd_data,
  input  logic                 wr_en,
  input  logic [UIDX_BITS-1:0] wr_idx,
  input  logic [SEQ_BITS-1:0]  wr_data
);

  logic [SEQ_BITS-1:0]      mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid;
  logic [SEQ_BITS-1:0]      raw;
  logic                     raw_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      raw <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      raw_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        raw_valid <= valid[rd_idx];
      end
    end
  end

  assign rd_data = raw_valid ? raw : '0;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the store sequence bloom filter: directed and random
// store, reserve, complete, lookup and load-check words are predicted by a
// behavioral copy of both tables and compared field by field at the output
// ----------------------------------------------------------------------------
module tb_top;
  import ssbf_pkg::*;

  typedef struct packed {
    logic                skip;
    logic                hit;
    logic [SEQ_BITS-1:0] last;
  } verdict_t;

  localparam int WATCHDOG_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] op = '0;
  logic [ADDR_BITS-1:0] addr = '0;
  logic [SIZE_BITS-1:0] access_size = '0;
  logic [SEQ_BITS-1:0] seq = '0;
  logic [SEQ_BITS-1:0] bound_seq = '0;
  logic bypass_hint = 1'b0;
  logic split_access = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic verify_skip;
  logic hit;
  logic [SEQ_BITS-1:0] last_seq;

  // table copy
  logic                   tv_valid [SETS*WAYS];
  logic [TAG_BITS-1:0]    tv_tag   [SETS*WAYS];
  logic [SEQ_BITS-1:0]    tv_seq   [SETS*WAYS];
  logic [OFFSET_BITS-1:0] tv_off   [SETS*WAYS];
  logic [SIZE_BITS-1:0]   tv_size  [SETS*WAYS];
  logic [SEQ_BITS-1:0]    utab     [TABLE_ENTRIES];

  verdict_t pending_verdicts[$];
  int err_count = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;
  bit idle_en = 1'b1;
  logic [SEQ_BITS-1:0] seq_now = 32'd100;

  store_sequence_bloom_filter uut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic verdict_t predict_word(logic [2:0] o, logic [ADDR_BITS-1:0] a,
                                            logic [SIZE_BITS-1:0] sz,
                                            logic [SEQ_BITS-1:0] sq,
                                            logic [SEQ_BITS-1:0] bnd, logic pb, logic sp);
    verdict_t r;
    int base;
    int e;
    int pick;
    logic [TAG_BITS-1:0] t;
    logic [UIDX_BITS-1:0] ui;
    logic [SEQ_BITS-1:0] young;
    r = '0;
    if (o > OP_LOOKUP) return r;
    base = int'(a[ADDR_SHIFT +: SET_BITS]) * WAYS;
    t = a[ADDR_SHIFT+SET_BITS +: TAG_BITS];
    ui = a[UIDX_BITS-1:0] ^ a[UIDX_BITS +: UIDX_BITS] ^ a[2*UIDX_BITS +: UIDX_BITS];
    e = -1;
    for (int w = 0; w < WAYS; w++)
      if (e < 0 && tv_valid[base+w] && tv_tag[base+w] == t) e = base + w;
    r.hit = (e >= 0);
    if ((o == OP_COMMIT || o == OP_RESERVE) && e < 0) begin
      pick = -1;
      for (int w = 0; w < WAYS; w++)
        if (pick < 0 && !tv_valid[base+w]) pick = base + w;
      if (pick < 0) begin
        pick = base;
        for (int w = 1; w < WAYS; w++)
          if (tv_seq[base+w] < tv_seq[pick]) pick = base + w;
      end
      tv_valid[pick] = 1'b1;
      tv_tag[pick] = t;
      tv_seq[pick] = sq;
      tv_off[pick] = '0;
      tv_size[pick] = '0;
      if (o == OP_RESERVE) return r;
      e = pick;
    end
    case (o)
      OP_COMMIT: begin
        tv_seq[e] = sq;
        tv_off[e] = a[OFFSET_BITS-1:0];
        tv_size[e] = sz;
        utab[ui] = sq;
      end
      OP_CHECK: begin
        if (sp) r.skip = 1'b0;
        else if (pb) r.skip = e >= 0 && tv_seq[e] == bnd &&
                              tv_off[e] == a[OFFSET_BITS-1:0] && tv_size[e] == sz;
        else if (e >= 0) r.skip = tv_seq[e] > 0 && tv_seq[e] <= bnd;
        else begin
          young = '0;
          for (int w = 0; w < WAYS; w++)
            if (tv_valid[base+w] && tv_seq[base+w] > young) young = tv_seq[base+w];
          r.skip = (young > 0 && young <= bnd) || utab[ui] <= bnd;
        end
      end
      OP_COMPLETE: if (e >= 0 && tv_seq[e] < sq) tv_seq[e] = sq;
      OP_LOOKUP: r.last = (e >= 0) ? tv_seq[e] : '0;
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_word(logic [2:0] o, logic [ADDR_BITS-1:0] a, logic [SIZE_BITS-1:0] sz,
                           logic [SEQ_BITS-1:0] sq, logic [SEQ_BITS-1:0] bnd,
                           logic pb, logic sp);
    while (idle_en && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    addr <= a;
    access_size <= sz;
    seq <= sq;
    bound_seq <= bnd;
    bypass_hint <= pb;
    split_access <= sp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_verdicts.insert(pending_verdicts.size(),
                            predict_word(o, a, sz, sq, bnd, pb, sp));
  endtask

  // address built from set, tag and byte offset
  function automatic logic [ADDR_BITS-1:0] addr_of(int tg, int st, int off);
    return (ADDR_BITS'(tg) << (ADDR_SHIFT + SET_BITS)) | (ADDR_BITS'(st) << ADDR_SHIFT) |
           ADDR_BITS'(off);
  endfunction

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= idle_en && ($urandom_range(99) < 28);
    end
  end

  always @(posedge clk) begin
    verdict_t x;
    if (!rst && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result word");
        err_count++;
      end else begin
        x = pending_verdicts.pop_front();
        if (verify_skip !== x.skip) begin
          $error("verify_skip exp %0d got %0d", x.skip, verify_skip);
          err_count++;
        end
        if (hit !== x.hit) begin
          $error("hit exp %0d got %0d", x.hit, hit);
          err_count++;
        end
        if (last_seq !== x.last) begin
          $error("last_seq exp %0h got %0h", x.last, last_seq);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic test_each_op;
    send_word(OP_LOOKUP, addr_of(1, 2, 0), 4'd0, 32'd0, 32'd0, 1'b0, 1'b0);
    send_word(OP_CHECK, addr_of(1, 2, 0), 4'd8, 32'd0, 32'd0, 1'b0, 1'b0);
    send_word(OP_COMMIT, addr_of(1, 2, 5), 4'd4, 32'd50, 32'd0, 1'b0, 1'b0);
    send_word(OP_RESERVE, addr_of(3, 2, 0), 4'd0, 32'd60, 32'd0, 1'b0, 1'b0);
    send_word(OP_RESERVE, addr_of(3, 2, 0), 4'd0, 32'd70, 32'd0, 1'b0, 1'b0);
    send_word(OP_COMPLETE, addr_of(3, 2, 0), 4'd0, 32'd65, 32'd0, 1'b0, 1'b0);
    send_word(OP_COMPLETE, addr_of(3, 2, 0), 4'd0, 32'd55, 32'd0, 1'b0, 1'b0);
    send_word(OP_LOOKUP, addr_of(3, 2, 0), 4'd0, 32'd0, 32'd0, 1'b0, 1'b0);
  endtask

  task automatic test_load_check;
    send_word(OP_CHECK, addr_of(1, 2, 5), 4'd4, 32'd0, 32'd50, 1'b1, 1'b0);
    send_word(OP_CHECK, addr_of(1, 2, 4), 4'd4, 32'd0, 32'd50, 1'b1, 1'b0);
    send_word(OP_CHECK, addr_of(1, 2, 5), 4'd4, 32'd0, 32'd50, 1'b0, 1'b1);
    send_word(OP_CHECK, addr_of(1, 2, 5), 4'd4, 32'd0, 32'd49, 1'b0, 1'b0);
    send_word(OP_CHECK, addr_of(9, 2, 0), 4'd2, 32'd0, 32'd70, 1'b0, 1'b0);
    send_word(OP_CHECK, addr_of(9, 2, 0), 4'd2, 32'd0, 32'd10, 1'b0, 1'b0);
  endtask

  task automatic test_eviction;
    send_word(OP_COMMIT, addr_of(4, 7, 0), 4'd1, 32'd30, 32'd0, 1'b0, 1'b0);
    send_word(OP_COMMIT, addr_of(5, 7, 0), 4'd1, 32'd30, 32'd0, 1'b0, 1'b0);
    send_word(OP_COMMIT, addr_of(6, 7, 0), 4'd1, 32'd40, 32'd0, 1'b0, 1'b0);
    send_word(OP_COMMIT, addr_of(7, 7, 0), 4'd1, 32'd20, 32'd0, 1'b0, 1'b0);
    send_word(OP_COMMIT, addr_of(8, 7, 0), 4'd1, 32'd90, 32'd0, 1'b0, 1'b0);
    send_word(OP_RESERVE, addr_of(9, 7, 0), 4'd0, 32'd95, 32'd0, 1'b0, 1'b0);
    send_word(OP_LOOKUP, addr_of(5, 7, 0), 4'd0, 32'd0, 32'd0, 1'b0, 1'b0);
  endtask

  task automatic test_extremes;
    send_word(3'd5, '1, '1, '1, '1, 1'b1, 1'b1);
    send_word(3'd7, '0, '0, '0, '0, 1'b0, 1'b0);
    send_word(OP_COMMIT, '1, 4'hf, 32'hffff_ffff, 32'd0, 1'b0, 1'b0);
    send_word(OP_CHECK, '1, 4'hf, 32'd0, 32'hffff_ffff, 1'b1, 1'b0);
    send_word(OP_LOOKUP, '1, 4'd0, 32'd0, 32'd0, 1'b0, 1'b0);
  endtask

  task automatic random_word;
    int r;
    logic [2:0] o;
    logic [ADDR_BITS-1:0] a;
    logic [SEQ_BITS-1:0] sq;
    logic [SEQ_BITS-1:0] bnd;
    r = $urandom_range(99);
    o = r < 30 ? OP_COMMIT : r < 60 ? OP_CHECK : r < 70 ? OP_RESERVE :
        r < 80 ? OP_COMPLETE : r < 95 ? OP_LOOKUP : 3'($urandom_range(7, 5));
    if ($urandom_range(99) < 15) a = ADDR_BITS'({$urandom(), $urandom()});
    else a = addr_of($urandom_range(5), $urandom_range(3), $urandom_range(7)) |
             (ADDR_BITS'($urandom_range(1)) << 40);
    seq_now = seq_now + $urandom_range(1, 4);
    sq = $urandom_range(99) < 10 ? $urandom() : seq_now - $urandom_range(3);
    bnd = $urandom_range(99) < 10 ? $urandom() : seq_now - $urandom_range(12);
    send_word(o, a, 4'($urandom_range(15)), sq, bnd, 1'($urandom_range(1)),
              $urandom_range(3) == 0);
  endtask

  task automatic test_backpressure;
    hold_cycles = 80;
    for (int i = 0; i < 20; i++) random_word();
    in_valid <= 1'b0;
    wait (pending_verdicts.size() == 0);
  endtask

  task automatic test_random;
    for (int i = 0; i < 880; i++) begin
      idle_en = !(i >= 300 && i < 450);
      random_word();
    end
    idle_en = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < SETS*WAYS; i++) begin
      tv_valid[i] = 1'b0;
      tv_tag[i] = '0;
      tv_seq[i] = '0;
      tv_off[i] = '0;
      tv_size[i] = '0;
    end
    for (int i = 0; i < TABLE_ENTRIES; i++) utab[i] = '0;
    @(posedge clk);
    test_each_op();
    test_load_check();
    test_eviction();
    test_extremes();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    wait (pending_verdicts.size() == 0);
    repeat (20) @(posedge clk);
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ files.f @@
rtl/ssbf_pkg.sv
rtl/ssbf_tag_mem.sv
rtl/ssbf_utab.sv
rtl/store_sequence_bloom_filter.sv
bench/tb_top.sv
